// ----- src/breakpoint_table_interpolator_macros.svh -----
// ----------------------------------------------------------------------------
// Breakpoint table interpolator assertion macros
// Shared helpers for the concurrent checks of the interpolator.
// ----------------------------------------------------------------------------
`ifndef BREAKPOINT_TABLE_INTERPOLATOR_MACROS_SVH
`define BREAKPOINT_TABLE_INTERPOLATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTI_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BTI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/bti_pkg.sv -----
// ----------------------------------------------------------------------------
// bti_pkg
// Types, constants and helpers shared by the breakpoint table interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package bti_pkg;

   // Table and field sizes.
   localparam int DEFAULT_DEPTH = 64;
   localparam int SLOT_W        = 6;
   localparam int DATA_W        = 32;
   localparam int CNT_W         = 7;
   localparam int MODE_W        = 2;
   localparam int FRAC_BITS     = 30;
   localparam int ACC_W         = 40;
   localparam int REQ_TDATA_W   = 72;

   // Register indexes of the configuration port.
   localparam logic CSR_MODE  = 1'b0;
   localparam logic CSR_COUNT = 1'b1;

   // Commands carried in tuser.
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // Interpolation modes.
   localparam logic [MODE_W-1:0] MODE_STEP    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_NEAREST = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LINEAR  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CUBIC   = 2'd3;

   // Reset values of the registers.
   localparam logic [MODE_W-1:0] MODE_RESET  = MODE_LINEAR;
   localparam logic [CNT_W-1:0]  COUNT_RESET = 7'd1;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHK0,
      ST_CHKN,
      ST_SCAN,
      ST_FETCH,
      ST_FRAC,
      ST_DIV,
      ST_MLO,
      ST_MHI,
      ST_MADD,
      ST_EMIT
   } state_type;

   // Status of the fraction divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Clamp a wide signed value to the signed 32-bit range.
   function automatic logic [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
      logic [DATA_W-1:0] r;
      if (x > 40'sh007FFFFFFF) begin
         r = 32'h7FFFFFFF;
      end else if (x < $signed(40'hFF80000000)) begin
         r = 32'h80000000;
      end else begin
         r = x[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- src/breakpoint_table_interpolator.sv -----
// ----------------------------------------------------------------------------
// breakpoint_table_interpolator
// Breakpoint table with step, nearest, linear and Catmull-Rom sampling.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the req_ stream; tuser is the command. A write transfer
// stores one breakpoint (time, level) and gives no result. A sample transfer
// gives one saturated Q16.16 level on the rsp_ stream. Mode and point count
// are written on the csr_ port, by the user only while the block is idle;
// the block itself does not enforce this. A sample at or beyond the table
// ends takes the end level without a scan. Otherwise its time is set by the
// interval scan through the single read port of the breakpoint memory (one
// entry a cycle) and, for linear and cubic, the bit-serial divider for the
// fraction, which is skipped when the fraction is zero or one.
// Writes are taken whenever the block is idle. One sample is worked on at a time;
// the next transfer is taken while a finished result still waits on rsp_.
// Reset puts mode to linear and the point count to one; table contents stay
// undefined until written. When the receiver stalls, a second finished result
// waits in the sequencer until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none
`include "breakpoint_table_interpolator_macros.svh"

module breakpoint_table_interpolator
   import bti_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Request stream.
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // slot[5:0], at_time[37:6], level[69:38]
   input  wire logic                   req_tuser,  // cmd[0]
   // Result stream.
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      logic [DATA_W-1:0]      rsp_tdata,  // sampled_level[31:0]
   // Configuration port.
   input  wire logic                   csr_we,
   input  wire logic                   csr_addr,
   input  wire logic [CNT_W-1:0]       csr_wdata
);

   localparam int IW = $clog2(TABLE_DEPTH);

   state_type state_ff, state_in;

   logic [MODE_W-1:0] mode_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [IW-1:0]     last_ff, last_in;

   logic signed [DATA_W-1:0] t_ff, t_in, t0_ff, t0_in, t1_ff, t1_in;
   logic signed [DATA_W-1:0] y0_ff, y0_in, y1_ff, y1_in, y2_ff, y2_in, y3_ff, y3_in;
   logic [IW-1:0]            k_ff, k_in, i_ff, i_in;
   logic [1:0]               fcnt_ff, fcnt_in, hcnt_ff, hcnt_in;
   logic [FRAC_BITS:0]       f_ff, f_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, c2_ff, c2_in, c1_ff, c1_in, c0_ff, c0_in;
   logic                     lin_ff, lin_in;
   logic signed [53:0]       lo_ff, lo_in, hi_ff, hi_in;
   logic [DATA_W-1:0]        res_ff, res_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]        rsp_data_ff, rsp_data_in;

   logic                    req_accept;
   logic [IW-1:0]           mem_raddr;
   logic                    mem_we;
   logic [2*DATA_W-1:0]     mem_rdata;
   logic signed [DATA_W-1:0] rd_time, rd_level;
   logic [IW-1:0]           i0_idx, i3_idx;
   logic [IW:0]             i_plus2;

   logic signed [DATA_W:0]  d_val, span_val, dr_val;
   logic signed [ACC_W-1:0] ey0, ey1, ey2, ey3;
   logic signed [ACC_W-1:0] c3_val, c2_val, c1_val, c0_val;

   logic signed [20:0]      mul_a;
   logic signed [DATA_W:0]  mul_b;
   logic signed [53:0]      prod;
   logic signed [73:0]      full;
   logic signed [ACC_W-1:0] m_val, addend, sum_val;

   logic                    div_start;
   logic [FRAC_BITS-1:0]    div_q;
   div_status_type          div_st;

   // Effective point count, clamped to [1, TABLE_DEPTH], as a last index.
   always_comb begin
      int n;
      n = (count_ff == '0) ? 1 : int'(count_ff);
      if (n > TABLE_DEPTH) begin
         n = TABLE_DEPTH;
      end
      last_in = IW'(n - 1);
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // Breakpoint writes go straight to memory; slots beyond the table are dropped.
   assign mem_we = req_accept && (req_tuser == CMD_WRITE)
                   && (32'(req_tdata[SLOT_W-1:0]) < TABLE_DEPTH);

   bti_mem #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (2 * DATA_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (IW'(32'(req_tdata[SLOT_W-1:0]))),
      .wr_data (req_tdata[69:6]),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign rd_time  = mem_rdata[DATA_W-1:0];
   assign rd_level = mem_rdata[2*DATA_W-1:DATA_W];

   // Neighbor indexes for the cubic, clamped to the table ends.
   assign i0_idx  = (i_ff == '0) ? '0 : i_ff - 1'b1;
   assign i_plus2 = {1'b0, i_ff} + (IW+1)'(2);
   assign i3_idx  = (i_plus2 > {1'b0, last_ff}) ? last_ff : i_plus2[IW-1:0];

   // Interval offsets and cubic coefficients.
   assign d_val    = {t_ff[DATA_W-1], t_ff} - {t0_ff[DATA_W-1], t0_ff};
   assign span_val = {t1_ff[DATA_W-1], t1_ff} - {t0_ff[DATA_W-1], t0_ff};
   assign dr_val   = {t1_ff[DATA_W-1], t1_ff} - {t_ff[DATA_W-1], t_ff};
   assign ey0 = ACC_W'(y0_ff);
   assign ey1 = ACC_W'(y1_ff);
   assign ey2 = ACC_W'(y2_ff);
   assign ey3 = ACC_W'(y3_ff);
   assign c3_val = -ey0 + 40'sd3 * ey1 - 40'sd3 * ey2 + ey3;
   assign c2_val = 40'sd2 * ey0 - 40'sd5 * ey1 + 40'sd4 * ey2 - ey3;
   assign c1_val = ey2 - ey0;
   assign c0_val = 40'sd2 * ey1;

   bti_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (d_val[DATA_W-1:0]),
      .den    (span_val[DATA_W-1:0]),
      .quot   (div_q),
      .status (div_st)
   );

   // Shared multiplier: low then high half of the accumulator times the fraction.
   assign mul_a = (state_ff == ST_MLO) ? {1'b0, acc_ff[19:0]} : {acc_ff[39], acc_ff[39:20]};
   assign mul_b = {2'b00, f_ff};
   assign prod  = mul_a * mul_b;

   // Recombine halves and drop the fraction bits (floor).
   assign full    = (74'(hi_ff) <<< 20) + 74'(lo_ff);
   assign m_val   = full[FRAC_BITS+ACC_W-1:FRAC_BITS];
   assign addend  = lin_ff ? ey1 : ((hcnt_ff == 2'd0) ? c2_ff :
                                    (hcnt_ff == 2'd1) ? c1_ff : c0_ff);
   assign sum_val = m_val + addend;

   // Sequencer: next state, memory address and datapath loads.
   always_comb begin
      state_in  = state_ff;
      t_in      = t_ff;
      t0_in     = t0_ff;
      t1_in     = t1_ff;
      y0_in     = y0_ff;
      y1_in     = y1_ff;
      y2_in     = y2_ff;
      y3_in     = y3_ff;
      k_in      = k_ff;
      i_in      = i_ff;
      fcnt_in   = fcnt_ff;
      hcnt_in   = hcnt_ff;
      f_in      = f_ff;
      acc_in    = acc_ff;
      c2_in     = c2_ff;
      c1_in     = c1_ff;
      c0_in     = c0_ff;
      lin_in    = lin_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      res_in    = res_ff;
      mem_raddr = '0;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_tuser == CMD_SAMPLE)) begin
               t_in     = req_tdata[37:6];
               state_in = ST_CHK0;
            end
         end
         ST_CHK0: begin
            if ((last_ff == '0) || (t_ff <= rd_time)) begin
               res_in   = rd_level;
               state_in = ST_EMIT;
            end else begin
               mem_raddr = last_ff;
               state_in  = ST_CHKN;
            end
         end
         ST_CHKN: begin
            i_in = '0;
            if (t_ff >= rd_time) begin
               res_in   = rd_level;
               state_in = ST_EMIT;
            end else if (last_ff == IW'(1)) begin
               mem_raddr = '0;
               fcnt_in   = '0;
               state_in  = ST_FETCH;
            end else begin
               mem_raddr = IW'(1);
               k_in      = IW'(1);
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Keep the last entry whose time is at or below the sample time.
            if (rd_time <= t_ff) begin
               i_in = k_ff;
            end
            if (k_ff == last_ff - 1'b1) begin
               mem_raddr = i_in;
               fcnt_in   = '0;
               state_in  = ST_FETCH;
            end else begin
               k_in      = k_ff + 1'b1;
               mem_raddr = k_ff + 1'b1;
            end
         end
         ST_FETCH: begin
            fcnt_in = fcnt_ff + 1'b1;
            case (fcnt_ff)
               2'd0: begin
                  t0_in     = rd_time;
                  y1_in     = rd_level;
                  mem_raddr = i_ff + 1'b1;
               end
               2'd1: begin
                  t1_in     = rd_time;
                  y2_in     = rd_level;
                  mem_raddr = i0_idx;
               end
               2'd2: begin
                  y0_in     = rd_level;
                  mem_raddr = i3_idx;
               end
               default: begin
                  y3_in    = rd_level;
                  state_in = ST_FRAC;
               end
            endcase
         end
         ST_FRAC: begin
            lin_in  = (mode_ff == MODE_LINEAR) || (last_ff < IW'(3));
            acc_in  = lin_in ? (ey2 - ey1) : c3_val;
            c2_in   = c2_val;
            c1_in   = c1_val;
            c0_in   = c0_val;
            hcnt_in = '0;
            case (mode_ff)
               MODE_STEP: begin
                  res_in   = y1_ff;
                  state_in = ST_EMIT;
               end
               MODE_NEAREST: begin
                  res_in   = (d_val <= dr_val) ? y1_ff : y2_ff;
                  state_in = ST_EMIT;
               end
               default: begin
                  if ((span_val <= 0) || (d_val <= 0)) begin
                     f_in     = '0;
                     state_in = ST_MLO;
                  end else if (d_val >= span_val) begin
                     f_in     = (FRAC_BITS+1)'(1) << FRAC_BITS;
                     state_in = ST_MLO;
                  end else begin
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
               end
            endcase
         end
         ST_DIV: begin
            if (div_st.done) begin
               f_in     = {1'b0, div_q};
               state_in = ST_MLO;
            end
         end
         ST_MLO: begin
            lo_in    = prod;
            state_in = ST_MHI;
         end
         ST_MHI: begin
            hi_in    = prod;
            state_in = ST_MADD;
         end
         ST_MADD: begin
            if (lin_ff || (hcnt_ff == 2'd2)) begin
               res_in   = sat32(lin_ff ? sum_val : (sum_val >>> 1));
               state_in = ST_EMIT;
            end else begin
               acc_in   = sum_val;
               hcnt_in  = hcnt_ff + 1'b1;
               state_in = ST_MLO;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: loads from the sequencer when free or being drained.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if ((state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready)) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_RESET;
         count_ff     <= COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && (csr_addr == CSR_MODE)) begin
            mode_ff <= csr_wdata[MODE_W-1:0];
         end
         if (csr_we && (csr_addr == CSR_COUNT)) begin
            count_ff <= csr_wdata;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      t_ff        <= t_in;
      t0_ff       <= t0_in;
      t1_ff       <= t1_in;
      y0_ff       <= y0_in;
      y1_ff       <= y1_in;
      y2_ff       <= y2_in;
      y3_ff       <= y3_in;
      k_ff        <= k_in;
      i_ff        <= i_in;
      fcnt_ff     <= fcnt_in;
      hcnt_ff     <= hcnt_in;
      f_ff        <= f_in;
      acc_ff      <= acc_in;
      c2_ff       <= c2_in;
      c1_ff       <= c1_in;
      c0_ff       <= c0_in;
      lin_ff      <= lin_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks on the sequencer.
   `BTI_ASSERT_SAME(a_div_done_in_wait, clock, reset, div_st.done, state_ff == ST_DIV, "divider finished outside its wait state")
   `BTI_ASSERT_NEXT(a_sample_starts, clock, reset, req_accept && (req_tuser == CMD_SAMPLE), state_ff == ST_CHK0, "sample transfer did not start a lookup")
   `BTI_ASSERT_NEXT(a_write_stays_idle, clock, reset, req_accept && (req_tuser == CMD_WRITE), state_ff == ST_IDLE, "write transfer left the idle state")

endmodule

`default_nettype wire

// ----- src/bti_mem.sv -----
// ----------------------------------------------------------------------------
// bti_mem
// Breakpoint store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module bti_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered data.
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- src/bti_div.sv -----
// ----------------------------------------------------------------------------
// bti_div
// Restoring divider giving floor(num * 2^30 / den) for num < den, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bti_div
   import bti_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [DATA_W-1:0]    num,
   input  wire logic [DATA_W-1:0]    den,
   output      logic [FRAC_BITS-1:0] quot,
   output      div_status_type       status
);

   localparam int STEP_W = $clog2(FRAC_BITS + 1);

   logic [DATA_W-1:0]    rem_ff, rem_in;
   logic [DATA_W-1:0]    den_ff, den_in;
   logic [FRAC_BITS-1:0] q_ff, q_in;
   logic [STEP_W-1:0]    cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DATA_W:0]      rem2;
   logic [DATA_W:0]      diff;
   logic                 ge;

   // One shift and trial subtract per cycle.
   assign rem2 = {rem_ff, 1'b0};
   assign diff = rem2 - {1'b0, den_ff};
   assign ge   = rem2 >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DATA_W-1:0] : rem2[DATA_W-1:0];
         q_in   = {q_ff[FRAC_BITS-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(FRAC_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign quot        = q_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire
